// ===== sv/qsd_pkg.sv =====
// ----------------------------------------------------------------------------
// qsd_pkg: shared types and constants of the block-scaled dot product
// Field widths, controller states, datapath operations and the command and
// status structs between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package qsd_pkg;

  // field widths
  localparam int unsigned ACT_W     = 8;
  localparam int unsigned WB_W      = 8;
  localparam int unsigned NIB_W     = 4;
  localparam int unsigned SCALE_W   = 24;
  localparam int unsigned PROD_W    = 12;
  localparam int unsigned MUL_W     = 2 * SCALE_W;
  localparam int unsigned DOT_W     = 64;
  localparam int unsigned RND_SHIFT = 16;

  // largest magnitude of one activation times one offset nibble
  localparam int unsigned PROD_MAX  = 1024;

  // rounding constant: one half of the dropped Q16 fraction
  localparam logic [DOT_W-1:0] ROUND_HALF = 64'h0000_0000_0000_8000;

  // saturation limits of the accumulator
  localparam logic [DOT_W-1:0] DOT_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [DOT_W-1:0] DOT_MIN = 64'h8000_0000_0000_0000;

  // term selection: first or second block of the pair
  localparam logic TERM_FIRST  = 1'b0;
  localparam logic TERM_SECOND = 1'b1;

  // positions of the latched scales
  localparam int unsigned SC_ACT_FIRST  = 0;
  localparam int unsigned SC_ACT_SECOND = 1;
  localparam int unsigned SC_WT_FIRST   = 2;
  localparam int unsigned SC_WT_SECOND  = 3;
  localparam int unsigned SC_NUM        = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_LO,
    ST_HI,
    ST_COMB,
    ST_ACC,
    ST_OUT
  } qsd_state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SCALE,
    OP_LO,
    OP_HI,
    OP_COMB,
    OP_ACC
  } qsd_op_e;

  typedef struct packed {
    logic    take;
    qsd_op_e op;
    logic    term;
    logic    clr_sums;
    logic    load_out;
  } qsd_cmd_t;

  typedef struct packed {
    logic flush;
    logic pend_last;
    logic out_free;
  } qsd_status_t;

  typedef struct packed {
    logic signed [ACT_W-1:0]   act_low;
    logic signed [ACT_W-1:0]   act_high;
    logic        [WB_W-1:0]    weight_byte;
    logic signed [SCALE_W-1:0] scale_act_first;
    logic signed [SCALE_W-1:0] scale_act_second;
    logic signed [SCALE_W-1:0] scale_wt_first;
    logic signed [SCALE_W-1:0] scale_wt_second;
    logic                      last;
  } qsd_item_t;

endpackage

`default_nettype wire

// ===== sv/qsd_in_if.sv =====
// ----------------------------------------------------------------------------
// qsd_in_if: input channel of the block-scaled dot product
// Valid/ready channel carrying two activations, a weight byte, four scales
// and the last mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface qsd_in_if;

  logic                               valid;
  logic                               ready;
  logic signed [qsd_pkg::ACT_W-1:0]   act_low;
  logic signed [qsd_pkg::ACT_W-1:0]   act_high;
  logic        [qsd_pkg::WB_W-1:0]    weight_byte;
  logic signed [qsd_pkg::SCALE_W-1:0] scale_act_first;
  logic signed [qsd_pkg::SCALE_W-1:0] scale_act_second;
  logic signed [qsd_pkg::SCALE_W-1:0] scale_wt_first;
  logic signed [qsd_pkg::SCALE_W-1:0] scale_wt_second;
  logic                               last;

  modport source (
    output valid, act_low, act_high, weight_byte, scale_act_first,
           scale_act_second, scale_wt_first, scale_wt_second, last,
    input  ready
  );

  modport sink (
    input  valid, act_low, act_high, weight_byte, scale_act_first,
           scale_act_second, scale_wt_first, scale_wt_second, last,
    output ready
  );

endinterface

`default_nettype wire

// ===== sv/qsd_out_if.sv =====
// ----------------------------------------------------------------------------
// qsd_out_if: result channel of the block-scaled dot product
// Valid/ready channel carrying the finished dot product and its flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface qsd_out_if;

  logic                             valid;
  logic                             ready;
  logic signed [qsd_pkg::DOT_W-1:0] dot_value;
  logic                             misaligned;

  modport source (
    output valid, dot_value, misaligned,
    input  ready
  );

  modport sink (
    input  valid, dot_value, misaligned,
    output ready
  );

endinterface

`default_nettype wire

// ===== sv/qsd_ctrl.sv =====
// ----------------------------------------------------------------------------
// qsd_ctrl: sequencer of the block-scaled dot product
// Takes items, runs the five-step scaling sequence for each of the two block
// terms at a group end or last mark, and after a last mark hands the result
// to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module qsd_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire qsd_pkg::qsd_status_t status_i,
  output qsd_pkg::qsd_cmd_t         cmd_o
);

  qsd_pkg::qsd_state_e state_q, state_d;
  logic                term_q, term_d;

  // state and term registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= qsd_pkg::ST_IDLE;
      term_q  <= qsd_pkg::TERM_FIRST;
    end else begin
      state_q <= state_d;
      term_q  <= term_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d      = state_q;
    term_d       = term_q;
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    cmd_o.op     = qsd_pkg::OP_NONE;
    cmd_o.term   = term_q;
    case (state_q)
      qsd_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (status_i.flush) begin
            state_d = qsd_pkg::ST_SCALE;
            term_d  = qsd_pkg::TERM_FIRST;
          end
        end
      end
      qsd_pkg::ST_SCALE: begin
        cmd_o.op = qsd_pkg::OP_SCALE;
        state_d  = qsd_pkg::ST_LO;
      end
      qsd_pkg::ST_LO: begin
        cmd_o.op = qsd_pkg::OP_LO;
        state_d  = qsd_pkg::ST_HI;
      end
      qsd_pkg::ST_HI: begin
        cmd_o.op = qsd_pkg::OP_HI;
        state_d  = qsd_pkg::ST_COMB;
      end
      qsd_pkg::ST_COMB: begin
        cmd_o.op = qsd_pkg::OP_COMB;
        state_d  = qsd_pkg::ST_ACC;
      end
      qsd_pkg::ST_ACC: begin
        cmd_o.op = qsd_pkg::OP_ACC;
        if (term_q == qsd_pkg::TERM_FIRST) begin
          term_d  = qsd_pkg::TERM_SECOND;
          state_d = qsd_pkg::ST_SCALE;
        end else begin
          cmd_o.clr_sums = 1'b1;
          state_d = status_i.pend_last ? qsd_pkg::ST_OUT : qsd_pkg::ST_IDLE;
        end
      end
      qsd_pkg::ST_OUT: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = qsd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = qsd_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // an item that closes a group starts scaling with the first term
  a_flush_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == qsd_pkg::ST_IDLE && in_valid_i && status_i.flush) |=>
    (state_q == qsd_pkg::ST_SCALE && term_q == qsd_pkg::TERM_FIRST))
    else $error("flush did not start the scaling sequence");

  // the second term always follows the first
  a_second_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == qsd_pkg::ST_ACC && term_q == qsd_pkg::TERM_FIRST) |=>
    (state_q == qsd_pkg::ST_SCALE && term_q == qsd_pkg::TERM_SECOND))
    else $error("second block term skipped");
`endif

endmodule

`default_nettype wire

// ===== sv/qsd_dp.sv =====
// ----------------------------------------------------------------------------
// qsd_dp: datapath of the block-scaled dot product
// Block sums, group position, latched scales, one shared 24x24 multiplier,
// rounding, the saturating Q16 accumulator and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module qsd_dp #(
  parameter int unsigned BLOCK_LEN = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire qsd_pkg::qsd_item_t   item_i,
  input  wire qsd_pkg::qsd_cmd_t    cmd_i,
  output qsd_pkg::qsd_status_t      status_o,
  input  wire logic                 out_ready_i,
  output logic                      out_valid_o,
  output logic signed [qsd_pkg::DOT_W-1:0] dot_value_o,
  output logic                      misaligned_o
);

  localparam int unsigned POS_W   = $clog2(BLOCK_LEN);
  localparam int unsigned MAG_W   = $clog2(BLOCK_LEN * qsd_pkg::PROD_MAX + 1);
  localparam int unsigned SUM_W   = MAG_W + 1;
  localparam int unsigned SCALE_W = qsd_pkg::SCALE_W;
  localparam int unsigned MUL_W   = qsd_pkg::MUL_W;
  localparam int unsigned DOT_W   = qsd_pkg::DOT_W;
  localparam int unsigned NIB_W   = qsd_pkg::NIB_W;
  localparam int unsigned PROD_W  = qsd_pkg::PROD_W;
  localparam int unsigned RND     = qsd_pkg::RND_SHIFT;

  logic [POS_W-1:0]         pos_q, pos_d;
  logic signed [SUM_W-1:0]  sum_first_q, sum_first_d;
  logic signed [SUM_W-1:0]  sum_second_q, sum_second_d;
  logic signed [SCALE_W-1:0] scale_q [qsd_pkg::SC_NUM];
  logic [MUL_W-1:0]         mul_q;
  logic [SCALE_W-1:0]       p_hi_q;
  logic [MAG_W-1:0]         ms_q;
  logic                     neg_q;
  logic [DOT_W-1:0]         mag_q;
  logic signed [DOT_W-1:0]  acc_q, acc_d;
  logic                     last_q, mis_q;
  logic                     out_valid_q, out_valid_d;
  logic signed [DOT_W-1:0]  dot_q;
  logic                     out_mis_q;

  logic                     group_end;
  logic signed [NIB_W-1:0]  w_lo, w_hi;
  logic signed [PROD_W-1:0] prod_lo, prod_hi;
  logic signed [SUM_W-1:0]  sel_sum, sum_abs;
  logic signed [SCALE_W-1:0] sel_sa, sel_sw;
  logic [SCALE_W-1:0]       sa_u, sw_u, sa_mag, sw_mag;
  logic [MAG_W-1:0]         ms;
  logic [SCALE_W-1:0]       mul_a, mul_b;
  logic [MUL_W-1:0]         mul_prod;
  logic [DOT_W:0]           r_ext, acc_ext, acc_sum;
  logic signed [DOT_W-1:0]  acc_sat;

  // group end and status
  assign group_end          = (pos_q == POS_W'(BLOCK_LEN - 1));
  assign status_o.flush     = group_end | item_i.last;
  assign status_o.pend_last = last_q;
  assign status_o.out_free  = ~out_valid_q | out_ready_i;

  // nibble minus eight is the nibble with its top bit flipped, as 4-bit signed
  assign w_lo    = {~item_i.weight_byte[3], item_i.weight_byte[2:0]};
  assign w_hi    = {~item_i.weight_byte[7], item_i.weight_byte[6:4]};
  assign prod_lo = item_i.act_low * w_lo;
  assign prod_hi = item_i.act_high * w_hi;

  // position and block sums
  always_comb begin
    pos_d        = pos_q;
    sum_first_d  = sum_first_q;
    sum_second_d = sum_second_q;
    if (cmd_i.take) begin
      pos_d        = status_o.flush ? '0 : pos_q + 1'b1;
      sum_first_d  = sum_first_q + SUM_W'(prod_lo);
      sum_second_d = sum_second_q + SUM_W'(prod_hi);
    end else if (cmd_i.clr_sums) begin
      sum_first_d  = '0;
      sum_second_d = '0;
    end
  end

  // operands of the selected term
  always_comb begin
    sel_sum = (cmd_i.term == qsd_pkg::TERM_SECOND) ? sum_second_q : sum_first_q;
    sel_sa  = (cmd_i.term == qsd_pkg::TERM_SECOND) ? scale_q[qsd_pkg::SC_ACT_SECOND]
                                                   : scale_q[qsd_pkg::SC_ACT_FIRST];
    sel_sw  = (cmd_i.term == qsd_pkg::TERM_SECOND) ? scale_q[qsd_pkg::SC_WT_SECOND]
                                                   : scale_q[qsd_pkg::SC_WT_FIRST];
    sum_abs = sel_sum[SUM_W-1] ? -sel_sum : sel_sum;
    ms      = sum_abs[MAG_W-1:0];
    sa_u    = sel_sa;
    sw_u    = sel_sw;
    sa_mag  = sa_u[SCALE_W-1] ? (~sa_u + 1'b1) : sa_u;
    sw_mag  = sw_u[SCALE_W-1] ? (~sw_u + 1'b1) : sw_u;
  end

  // shared multiplier: fused scale, then sum times its low and high halves
  always_comb begin
    case (cmd_i.op)
      qsd_pkg::OP_SCALE: begin
        mul_a = sa_mag;
        mul_b = sw_mag;
      end
      qsd_pkg::OP_LO: begin
        mul_a = SCALE_W'(ms_q);
        mul_b = mul_q[SCALE_W-1:0];
      end
      qsd_pkg::OP_HI: begin
        mul_a = SCALE_W'(ms_q);
        mul_b = p_hi_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_prod = MUL_W'(mul_a) * MUL_W'(mul_b);
  end

  // rounded magnitude into the accumulator, add or subtract, then saturate
  always_comb begin
    r_ext   = (DOT_W + 1)'(mag_q[DOT_W-1:RND]);
    acc_ext = {acc_q[DOT_W-1], acc_q};
    acc_sum = acc_ext + (neg_q ? ~r_ext : r_ext) + (DOT_W + 1)'(neg_q);
    if (acc_sum[DOT_W] != acc_sum[DOT_W-1]) begin
      acc_sat = acc_sum[DOT_W] ? qsd_pkg::DOT_MIN : qsd_pkg::DOT_MAX;
    end else begin
      acc_sat = acc_sum[DOT_W-1:0];
    end
  end

  // accumulator and output valid
  always_comb begin
    acc_d = acc_q;
    if (cmd_i.op == qsd_pkg::OP_ACC) begin
      acc_d = acc_sat;
    end else if (cmd_i.load_out) begin
      acc_d = '0;
    end
    out_valid_d = out_valid_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      sum_first_q  <= '0;
      sum_second_q <= '0;
      acc_q        <= '0;
      last_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pos_q        <= pos_d;
      sum_first_q  <= sum_first_d;
      sum_second_q <= sum_second_d;
      acc_q        <= acc_d;
      out_valid_q  <= out_valid_d;
      if (cmd_i.take) begin
        last_q <= item_i.last;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      mis_q <= ~group_end;
      if (pos_q == '0) begin
        scale_q[qsd_pkg::SC_ACT_FIRST]  <= item_i.scale_act_first;
        scale_q[qsd_pkg::SC_ACT_SECOND] <= item_i.scale_act_second;
        scale_q[qsd_pkg::SC_WT_FIRST]   <= item_i.scale_wt_first;
        scale_q[qsd_pkg::SC_WT_SECOND]  <= item_i.scale_wt_second;
      end
    end
    case (cmd_i.op)
      qsd_pkg::OP_SCALE: begin
        mul_q <= mul_prod;
        ms_q  <= ms;
        neg_q <= sel_sum[SUM_W-1] ^ sel_sa[SCALE_W-1] ^ sel_sw[SCALE_W-1];
      end
      qsd_pkg::OP_LO: begin
        mul_q  <= mul_prod;
        p_hi_q <= mul_q[MUL_W-1:SCALE_W];
      end
      qsd_pkg::OP_HI: begin
        mul_q <= mul_prod;
        mag_q <= DOT_W'(mul_q);
      end
      qsd_pkg::OP_COMB: begin
        // high partial product stays below 2^40 over the block length range
        mag_q <= mag_q + {mul_q[DOT_W-SCALE_W-1:0], {SCALE_W{1'b0}}}
                 + qsd_pkg::ROUND_HALF;
      end
      default: begin
      end
    endcase
    if (cmd_i.load_out) begin
      dot_q     <= acc_q;
      out_mis_q <= mis_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign dot_value_o  = dot_q;
  assign misaligned_o = out_mis_q;

`ifndef SYNTHESIS
  // an item that closes a group or carries last restarts the position
  a_pos_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.take && status_o.flush) |=> (pos_q == '0))
    else $error("group position not restarted");

  // moving a result out leaves it pending and clears the accumulator
  a_load_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |=> (out_valid_q && acc_q == '0))
    else $error("result load did not clear the accumulator");
`endif

endmodule

`default_nettype wire

// ===== sv/q8_q4_block_scaled_dot_top.sv =====
// ----------------------------------------------------------------------------
// q8_q4_block_scaled_dot_top: int8 x packed 4-bit block-scaled dot product
// Each input beat carries one activation of each of a pair of BLOCK_LEN
// element blocks and one weight byte (low nibble minus 8 for the first block,
// high nibble minus 8 for the second); scales in signed Q8.16 are taken from
// the first beat of each group. Beats are taken only while idle. A beat that
// ends a group or carries last holds off further beats while the two block
// terms each pass five steps through one shared 24x24 multiplier (fused scale,
// two partial products, combine with round to nearest, saturating add to the
// 64-bit Q16 accumulator). After a last beat the result then moves into the
// output register, waiting while an earlier result is not yet taken. The
// result flags misaligned when last arrives before a group is complete;
// partial sums are still scaled.
// ----------------------------------------------------------------------------
`default_nettype none

module q8_q4_block_scaled_dot_top #(
  parameter int unsigned BLOCK_LEN = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  qsd_in_if.sink    in_i,
  qsd_out_if.source out_o
);

  qsd_pkg::qsd_item_t   item;
  qsd_pkg::qsd_cmd_t    cmd;
  qsd_pkg::qsd_status_t status;
  logic                 in_ready;

  // gather the input beat
  always_comb begin
    item.act_low          = in_i.act_low;
    item.act_high         = in_i.act_high;
    item.weight_byte      = in_i.weight_byte;
    item.scale_act_first  = in_i.scale_act_first;
    item.scale_act_second = in_i.scale_act_second;
    item.scale_wt_first   = in_i.scale_wt_first;
    item.scale_wt_second  = in_i.scale_wt_second;
    item.last             = in_i.last;
  end

  assign in_i.ready = in_ready;

  // sequencer
  qsd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath
  qsd_dp #(
    .BLOCK_LEN (BLOCK_LEN)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .dot_value_o  (out_o.dot_value),
    .misaligned_o (out_o.misaligned)
  );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench of the q8 x q4 block-scaled dot product
// A small scoreboard class predicts each dot product from the accepted input
// beats (block sums, group-end scaling with rounding, saturating Q16 sums)
// and checks every result beat. Directed beats cover the extremes and the
// rounding tie, then random dot products of mixed length follow: whole
// groups, early last marks and long ones at the largest magnitudes. Both
// channels idle at random, the result side holds off for a long stretch
// once, and the sender drains once.
// ----------------------------------------------------------------------------

module tb;

  localparam int unsigned BLOCK_LEN     = 32;
  localparam int unsigned N_ITEMS       = 1750;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned DRAIN_CYCLES  = 60;
  localparam int unsigned HOLD_AT_ITEM  = 300;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned CALM_FROM     = 700;
  localparam int unsigned CALM_TO       = 1000;
  localparam int unsigned PAUSE_AT_ITEM = 1300;
  localparam int unsigned IDLE_PCT      = 30;
  localparam int unsigned SCALE_W       = qsd_pkg::SCALE_W;
  localparam int unsigned DOT_W         = qsd_pkg::DOT_W;

  localparam logic [SCALE_W-1:0] SCALE_TOP = 24'h7f_ffff;
  localparam logic [SCALE_W-1:0] SCALE_BOT = 24'h80_0000;

  // mix of a random dot product
  typedef enum logic [1:0] {
    MIX_PLAIN,
    MIX_HOT_POS,
    MIX_HOT_NEG
  } dot_mix_e;

  typedef struct packed {
    logic signed [DOT_W-1:0] value;
    logic                    misaligned;
  } dot_result_t;

  // predicts dot products from accepted beats and checks result beats
  class dot_scoreboard;
    dot_result_t             pending_q[$];
    int unsigned             group_pos;
    int                      sum_first;
    int                      sum_second;
    longint                  scale_q[qsd_pkg::SC_NUM];
    logic signed [DOT_W-1:0] acc;
    int unsigned             errors;

    function new();
      group_pos  = 0;
      sum_first  = 0;
      sum_second = 0;
      acc        = '0;
      errors     = 0;
      foreach (scale_q[i]) scale_q[i] = 0;
    endfunction

    // block sum times fused scale, rounded to Q16, ties away from zero
    function automatic logic signed [DOT_W-1:0] scaled_term(int sum, longint sa,
                                                            longint sw);
      longint      fused;
      logic        neg;
      logic [63:0] mag_sum;
      logic [63:0] mag_fused;
      logic [63:0] rounded;
      fused     = sa * sw;
      neg       = (sum < 0) != (fused < 0);
      mag_sum   = (sum < 0) ? -longint'(sum) : longint'(sum);
      mag_fused = (fused < 0) ? -fused : fused;
      rounded   = (mag_sum * mag_fused + qsd_pkg::ROUND_HALF) >> qsd_pkg::RND_SHIFT;
      return neg ? -rounded : rounded;
    endfunction

    // signed 64-bit add clamped to the accumulator range
    function automatic logic signed [DOT_W-1:0] add_saturated(
        logic signed [DOT_W-1:0] a, logic signed [DOT_W-1:0] b);
      logic [DOT_W:0] s;
      s = {a[DOT_W-1], a} + {b[DOT_W-1], b};
      if (s[DOT_W] != s[DOT_W-1]) return s[DOT_W] ? qsd_pkg::DOT_MIN : qsd_pkg::DOT_MAX;
      return s[DOT_W-1:0];
    endfunction

    function automatic void flush_sums();
      acc = add_saturated(acc, scaled_term(sum_first, scale_q[qsd_pkg::SC_ACT_FIRST],
                                           scale_q[qsd_pkg::SC_WT_FIRST]));
      acc = add_saturated(acc, scaled_term(sum_second, scale_q[qsd_pkg::SC_ACT_SECOND],
                                           scale_q[qsd_pkg::SC_WT_SECOND]));
      sum_first  = 0;
      sum_second = 0;
    endfunction

    // one accepted input beat
    function automatic void note_input(qsd_pkg::qsd_item_t it);
      int          w_lo;
      int          w_hi;
      logic        group_end;
      dot_result_t res;
      if (group_pos == 0) begin
        scale_q[qsd_pkg::SC_ACT_FIRST]  = it.scale_act_first;
        scale_q[qsd_pkg::SC_ACT_SECOND] = it.scale_act_second;
        scale_q[qsd_pkg::SC_WT_FIRST]   = it.scale_wt_first;
        scale_q[qsd_pkg::SC_WT_SECOND]  = it.scale_wt_second;
      end
      w_lo = int'(it.weight_byte[qsd_pkg::NIB_W-1:0]) - 8;
      w_hi = int'(it.weight_byte[qsd_pkg::WB_W-1:qsd_pkg::NIB_W]) - 8;
      sum_first  += int'(it.act_low) * w_lo;
      sum_second += int'(it.act_high) * w_hi;
      group_end = (group_pos >= BLOCK_LEN - 1);
      if (group_end) begin
        group_pos = 0;
        flush_sums();
      end else begin
        group_pos++;
      end
      if (it.last) begin
        if (!group_end) flush_sums();
        res.value      = acc;
        res.misaligned = !group_end;
        pending_q.push_back(res);
        group_pos  = 0;
        sum_first  = 0;
        sum_second = 0;
        acc        = '0;
      end
    endfunction

    // one accepted result beat
    function automatic void check_result(logic signed [DOT_W-1:0] value,
                                         logic misaligned);
      dot_result_t want;
      if (pending_q.size() == 0) begin
        $error("result beat with no dot product pending: dot_value %0d", value);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (value !== want.value) begin
        $error("dot_value mismatch: expected %0d, actual %0d", want.value, value);
        errors++;
      end
      if (misaligned !== want.misaligned) begin
        $error("misaligned mismatch: expected %0b, actual %0b",
               want.misaligned, misaligned);
        errors++;
      end
    endfunction

    function automatic int unsigned pending();
      return pending_q.size();
    endfunction
  endclass

  logic          clk_i;
  logic          rst_ni;
  qsd_in_if      in_if ();
  qsd_out_if     out_if ();
  dot_scoreboard sb = new();
  int unsigned   items_sent;
  int unsigned   cycle_count;
  logic          calm;

  q8_q4_block_scaled_dot_top #(
    .BLOCK_LEN(BLOCK_LEN)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // handshake monitors
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        sb.note_input(qsd_pkg::qsd_item_t'{in_if.act_low, in_if.act_high,
                                           in_if.weight_byte, in_if.scale_act_first,
                                           in_if.scale_act_second, in_if.scale_wt_first,
                                           in_if.scale_wt_second, in_if.last});
      end
      if (out_if.valid && out_if.ready) begin
        sb.check_result(out_if.dot_value, out_if.misaligned);
      end
    end
  end

  // result side: random stalls, one long hold-off
  initial begin : result_sink
    int unsigned hold_left;
    logic        hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
      end else if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
        out_if.ready <= 1'b0;
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end else begin
        out_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  task automatic drive_fields(input qsd_pkg::qsd_item_t it);
    in_if.act_low          <= it.act_low;
    in_if.act_high         <= it.act_high;
    in_if.weight_byte      <= it.weight_byte;
    in_if.scale_act_first  <= it.scale_act_first;
    in_if.scale_act_second <= it.scale_act_second;
    in_if.scale_wt_first   <= it.scale_wt_first;
    in_if.scale_wt_second  <= it.scale_wt_second;
    in_if.last             <= it.last;
  endtask

  // offer one beat, with random idle cycles ahead of it, until taken
  task automatic send_item(input qsd_pkg::qsd_item_t it);
    calm = (items_sent >= CALM_FROM) && (items_sent < CALM_TO);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    drive_fields(it);
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
  endtask

  task automatic send_fixed(input logic [7:0] al, input logic [7:0] ah,
                            input logic [7:0] wb, input logic [SCALE_W-1:0] s0,
                            input logic [SCALE_W-1:0] s1,
                            input logic [SCALE_W-1:0] s2,
                            input logic [SCALE_W-1:0] s3, input logic last);
    send_item(qsd_pkg::qsd_item_t'{al, ah, wb, s0, s1, s2, s3, last});
  endtask

  function automatic qsd_pkg::qsd_item_t random_item(dot_mix_e mix, logic last);
    qsd_pkg::qsd_item_t it;
    it.act_low          = 8'($urandom);
    it.act_high         = 8'($urandom);
    it.weight_byte      = 8'($urandom);
    it.scale_act_first  = 24'($urandom);
    it.scale_act_second = 24'($urandom);
    it.scale_wt_first   = 24'($urandom);
    it.scale_wt_second  = 24'($urandom);
    it.last             = last;
    // largest products and scales, for the widest accumulator values
    if (mix != MIX_PLAIN) begin
      it.act_low          = 8'h80;
      it.act_high         = 8'h80;
      if ($urandom_range(99) < 90) it.weight_byte = 8'h00;
      it.scale_act_first  = SCALE_BOT;
      it.scale_act_second = SCALE_BOT;
      it.scale_wt_first   = (mix == MIX_HOT_POS) ? SCALE_BOT : SCALE_TOP;
      it.scale_wt_second  = (mix == MIX_HOT_POS) ? SCALE_BOT : SCALE_TOP;
    end
    return it;
  endfunction

  // stimulus
  initial begin : stimulus
    int unsigned len;
    int unsigned pick;
    dot_mix_e    mix;
    logic        paused;
    items_sent = 0;
    calm       = 1'b0;
    paused     = 1'b0;
    rst_ni     <= 1'b0;
    in_if.valid <= 1'b0;
    drive_fields('0);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single-beat dot products at the extremes, all flagged misaligned
    send_fixed(8'h7f, 8'h80, 8'h0f, SCALE_TOP, SCALE_BOT, SCALE_BOT, SCALE_TOP, 1'b1);
    send_fixed(8'h80, 8'h80, 8'h00, SCALE_BOT, SCALE_BOT, SCALE_BOT, SCALE_BOT, 1'b1);
    send_fixed(8'h80, 8'h7f, 8'hf0, SCALE_TOP, SCALE_TOP, SCALE_TOP, SCALE_TOP, 1'b1);
    send_fixed(8'h00, 8'h00, 8'h88, 24'h0, 24'h0, 24'h0, 24'h0, 1'b1);
    send_fixed(8'hff, 8'h01, 8'hff, SCALE_TOP, 24'hff_ffff, 24'h00_0001, SCALE_BOT, 1'b1);
    // rounding ties: one half rounds away from zero on both signs
    send_fixed(8'h01, 8'hff, 8'h99, 24'h1, 24'h3, 24'h8000, 24'h8000, 1'b1);
    send_fixed(8'hff, 8'h01, 8'h99, 24'h1, 24'h5, 24'h8000, 24'h8000, 1'b1);
    // short run: scales on later beats must be ignored
    send_fixed(8'd100, 8'hce, 8'h3c, 24'h01_0000, 24'h02_0000, 24'h00_8000,
               24'hff_0000, 1'b0);
    send_fixed(8'hf9, 8'h09, 8'ha5, SCALE_TOP, SCALE_BOT, SCALE_TOP, SCALE_BOT, 1'b0);
    send_fixed(8'h7f, 8'h80, 8'h7f, 24'h0, 24'h0, 24'h0, 24'h0, 1'b0);
    send_fixed(8'h80, 8'h7f, 8'hf7, 24'h12_3456, 24'h65_4321, 24'h0, 24'h1, 1'b0);
    send_fixed(8'h55, 8'haa, 8'h5a, 24'h0, 24'h0, 24'h0, 24'h0, 1'b1);
    // back-to-back single-beat dots
    send_fixed(8'h40, 8'hc0, 8'h1e, 24'h00_4000, 24'hff_c000, 24'h01_0000,
               24'h01_0000, 1'b1);
    send_fixed(8'hc0, 8'h40, 8'he1, 24'h00_4000, 24'hff_c000, 24'h01_0000,
               24'h01_0000, 1'b1);

    // random dot products of mixed shape
    while (items_sent < N_ITEMS) begin
      if (!paused && items_sent >= PAUSE_AT_ITEM) begin
        paused = 1'b1;
        in_if.valid <= 1'b0;
        // let the monitor note the beat taken at this edge first
        @(posedge clk_i);
        while (sb.pending() != 0) @(posedge clk_i);
      end
      pick = $urandom_range(99);
      mix  = MIX_PLAIN;
      if (pick < 10) begin
        mix = $urandom_range(1) ? MIX_HOT_POS : MIX_HOT_NEG;
        len = 3 * BLOCK_LEN + ($urandom_range(1) ? 0 : $urandom_range(1, BLOCK_LEN - 1));
      end else if (pick < 45) begin
        len = BLOCK_LEN * $urandom_range(1, 2);
      end else if (pick < 75) begin
        len = $urandom_range(1, 3 * BLOCK_LEN);
      end else begin
        len = $urandom_range(1, 6);
      end
      for (int unsigned i = 0; i < len; i++) begin
        send_item(random_item(mix, i == len - 1));
      end
    end

    // drain
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
